### hw/rtl/excluded_volume_energy_sum_unit_defines.svh
// Assertion macros shared by the checker of the excluded volume energy sum unit.
// Each macro expects clk to be visible where it is used; the first two also expect rst_n.
`ifndef EXCLUDED_VOLUME_ENERGY_SUM_UNIT_DEFINES_SVH
`define EXCLUDED_VOLUME_ENERGY_SUM_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define EVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is applied.
`define EVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define EVS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/evs_pkg.sv
// Shared types and constants of the excluded volume energy sum unit.
// No dependencies; every other file of the block but the defines header uses this package.
`timescale 1ns / 1ps

package evs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int R2_W          = 24;
  localparam int SIG_W         = 20;
  localparam int ENERGY_W      = 48;
  localparam int COUNT_W       = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int OP_W          = 48;
  localparam int PROD_W        = 2 * OP_W;
  localparam int HALF_W        = OP_W / 2;
  localparam int SS_W          = 2 * SIG_W;
  localparam int DIV_W         = 40;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [ENERGY_W-1:0] CAP = {ENERGY_W{1'b1}};

  localparam logic [CFG_W-1:0] LAMBDA_SQ_RST    = 16'd36864;
  localparam logic [CFG_W-1:0] INV_CUT_SQ_RST   = 16'd3544;
  localparam logic [CFG_W-1:0] ENERGY_SCALE_RST = 16'd6554;
  localparam logic [CFG_W-1:0] SLOPE_RST        = 16'd37807;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA_SQ    = 2'd0,
    CFG_INV_CUT_SQ   = 2'd1,
    CFG_ENERGY_SCALE = 2'd2,
    CFG_SLOPE        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [R2_W-1:0]  squared_distance;
    logic [SIG_W-1:0] pair_sigma;
    logic             last_pair;
  } in_word_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] total_energy;
    logic [COUNT_W-1:0]  pair_count;
    logic                saturated;
  } out_word_t;

  typedef struct packed {
    in_word_t word;
    logic     zero_dist;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] lambda_squared;
    logic [CFG_W-1:0] inverse_cutoff_squared;
    logic [CFG_W-1:0] energy_scale;
    logic [CFG_W-1:0] slope_factor;
  } cfg_regs_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] a;
    logic [OP_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [R2_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/excluded_volume_energy_sum_unit.sv
// The result word of the last pair of a set is ready in the same cycle as its term is
// summed, once the output slot is free. The back end works on one pair at a time, paced
// by the one shared 24 x 24 multiplier (twelve 48 x 48 products) and the divider's one
// quotient bit per cycle; a zero distance skips the divide. Synchronous reset clears
// the sum, count, flag, queues and loads the register defaults.
`timescale 1ns / 1ps

module excluded_volume_energy_sum_unit #(
  parameter int FRAC_BITS = evs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  evs_pkg::in_word_t               in_word,
  output logic                            out_empty,
  input  logic                            out_pop,
  output evs_pkg::out_word_t              out_word,
  input  logic                            cfg_wr_en,
  input  logic [evs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [evs_pkg::CFG_W-1:0]       cfg_wdata
);

  evs_pkg::cfg_regs_t cfg_r;
  evs_pkg::cmd_t      cmd;
  logic               cmd_valid;
  logic               cmd_pop;
  evs_pkg::mul_req_t  mul_req;
  evs_pkg::mul_rsp_t  mul_rsp;
  evs_pkg::div_req_t  div_req;
  evs_pkg::div_rsp_t  div_rsp;
  logic               out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lambda_squared         <= evs_pkg::LAMBDA_SQ_RST;
      cfg_r.inverse_cutoff_squared <= evs_pkg::INV_CUT_SQ_RST;
      cfg_r.energy_scale           <= evs_pkg::ENERGY_SCALE_RST;
      cfg_r.slope_factor           <= evs_pkg::SLOPE_RST;
    end else if (cfg_wr_en) begin
      unique case (evs_pkg::cfg_idx_t'(cfg_index))
        evs_pkg::CFG_LAMBDA_SQ:    cfg_r.lambda_squared         <= cfg_wdata;
        evs_pkg::CFG_INV_CUT_SQ:   cfg_r.inverse_cutoff_squared <= cfg_wdata;
        evs_pkg::CFG_ENERGY_SCALE: cfg_r.energy_scale           <= cfg_wdata;
        evs_pkg::CFG_SLOPE:        cfg_r.slope_factor           <= cfg_wdata;
        default:                   cfg_r                        <= cfg_r;
      endcase
    end
  end

  evs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  evs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  evs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  evs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg_r),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_empty = !out_valid;

endmodule

### hw/rtl/evs_front.sv
// Front end: accepts input words, flags a zero distance and queues them.
// Depends on evs_pkg.
`timescale 1ns / 1ps

module evs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  evs_pkg::in_word_t in_word,
  output logic              cmd_valid,
  output evs_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  localparam int PTR_W = $clog2(evs_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(evs_pkg::QUEUE_DEPTH + 1);

  evs_pkg::cmd_t    slot_r [evs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push_ok;
  evs_pkg::cmd_t    new_cmd;

  assign in_full   = (cnt_r == CNT_W'(evs_pkg::QUEUE_DEPTH));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = slot_r[rd_ptr_r];

  always_comb begin
    new_cmd.word      = in_word;
    new_cmd.zero_dist = (in_word.squared_distance == '0);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push_ok) - CNT_W'(cmd_pop);
    end
  end

endmodule

### hw/rtl/evs_mul.sv
// Shared 48 x 48 multiplier built from one 24 x 24 partial product per cycle.
// Depends on evs_pkg.
`timescale 1ns / 1ps

module evs_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  evs_pkg::mul_req_t req,
  output evs_pkg::mul_rsp_t rsp
);

  localparam int HW = evs_pkg::HALF_W;
  localparam int PW = evs_pkg::PROD_W;

  logic [evs_pkg::OP_W-1:0] a_r;
  logic [evs_pkg::OP_W-1:0] b_r;
  logic [PW-1:0]            acc_r;
  logic [2*HW-1:0]          pp_r;
  logic [1:0]               sh_r;
  logic [2:0]               step_r;
  logic                     busy_r;
  logic                     done_r;
  logic [HW-1:0]            a_half;
  logic [HW-1:0]            b_half;
  logic [PW-1:0]            pp_shifted;

  assign a_half = step_r[1] ? a_r[2*HW-1:HW] : a_r[HW-1:0];
  assign b_half = step_r[0] ? b_r[2*HW-1:HW] : b_r[HW-1:0];

  always_comb begin
    unique case (sh_r)
      2'd0:    pp_shifted = PW'(pp_r);
      2'd1:    pp_shifted = PW'(pp_r) << HW;
      default: pp_shifted = PW'(pp_r) << (2 * HW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          pp_r <= a_half * b_half;
          sh_r <= 2'(step_r[1]) + 2'(step_r[0]);
        end
        if (step_r != 3'd0) begin
          acc_r <= acc_r + pp_shifted;
        end
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

### hw/rtl/evs_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on evs_pkg.
`timescale 1ns / 1ps

module evs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  evs_pkg::div_req_t req,
  output evs_pkg::div_rsp_t rsp
);

  localparam int DW  = evs_pkg::DIV_W;
  localparam int VW  = evs_pkg::R2_W;
  localparam int CTW = $clog2(DW);

  logic [VW-1:0]  rem_r;
  logic [DW-1:0]  quo_r;
  logic [VW-1:0]  dv_r;
  logic [CTW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [VW:0]    rem_sh;
  logic [VW:0]    diff;
  logic           ge;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = (rem_sh >= {1'b0, dv_r});
  assign diff   = rem_sh - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.dividend;
        dv_r   <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
        quo_r <= {quo_r[DW-2:0], ge};
        if (cnt_r == CTW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### hw/rtl/evs_back.sv
// Back end: sequences the pair term over the shared multiplier and divider,
// accumulates the set and holds the result word. Depends on evs_pkg.
`timescale 1ns / 1ps

module evs_back #(
  parameter int FRAC_BITS = evs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  evs_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  evs_pkg::cfg_regs_t cfg,
  output evs_pkg::mul_req_t  mul_req,
  input  evs_pkg::mul_rsp_t  mul_rsp,
  output evs_pkg::div_req_t  div_req,
  input  evs_pkg::div_rsp_t  div_rsp,
  input  logic               out_pop,
  output logic               out_valid,
  output evs_pkg::out_word_t out_word
);

  localparam int EW = evs_pkg::ENERGY_W;
  localparam int OW = evs_pkg::OP_W;
  localparam int FW = evs_pkg::PROD_W + 1;
  localparam int CW = evs_pkg::COUNT_W;

  localparam logic [FW-1:0] RND    = FW'(1) << (FRAC_BITS - 1);
  localparam logic [FW-1:0] SG_RND = FW'(1) << (15 + FRAC_BITS);
  localparam logic [FW-1:0] Q16RND = FW'(1) << 15;

  typedef enum logic [3:0] {
    S_IDLE, S_SS, S_SG, S_A1, S_DIV, S_PX1, S_PX2, S_PX3,
    S_PA1, S_PA2, S_PA3, S_B, S_BR, S_INNER, S_TERM, S_ACC
  } state_t;

  state_t                   state_r;
  evs_pkg::mul_req_t        mul_req_r;
  evs_pkg::div_req_t        div_req_r;
  logic [evs_pkg::R2_W-1:0] r2_r;
  logic                     last_r;
  logic                     zero_r;
  logic                     sat_r;
  logic [evs_pkg::SS_W-1:0] ss_r;
  logic [EW-1:0]            sg2_r;
  logic [EW-1:0]            a1_r;
  logic [EW-1:0]            x_r;
  logic [EW-1:0]            x6_r;
  logic [EW-1:0]            seven_r;
  logic [EW-1:0]            sum1_r;
  logic [EW-1:0]            br2_r;
  logic [EW-1:0]            term_r;
  logic [EW-1:0]            acc_r;
  logic [CW-1:0]            cnt_r;
  logic                     ovf_r;
  logic                     out_valid_r;
  evs_pkg::out_word_t       out_r;

  logic [FW-1:0] q_full;
  logic [FW-1:0] q_shift;
  logic          q_ovf;
  logic [EW-1:0] q_val;
  logic [EW-1:0] sg_val;
  logic [EW-1:0] r16_val;
  logic [EW+2:0] seven_full;
  logic [EW:0]   sum1_full;
  logic [EW:0]   inner_full;
  logic [EW:0]   acc_full;
  logic [EW-1:0] inner_val;
  logic [EW-1:0] acc_val;
  logic [CW-1:0] cnt_val;
  logic          slot_free;

  always_comb begin
    q_full     = {1'b0, mul_rsp.p} + RND;
    q_shift    = q_full >> FRAC_BITS;
    q_ovf      = (q_full[FW-1:64] != '0) || (q_shift[FW-1:EW] != '0);
    q_val      = q_ovf ? evs_pkg::CAP : q_shift[EW-1:0];
    sg_val     = EW'(({1'b0, mul_rsp.p} + SG_RND) >> (16 + FRAC_BITS));
    r16_val    = EW'(({1'b0, mul_rsp.p} + Q16RND) >> 16);
    seven_full = (EW+3)'(q_val) * (EW+3)'(7);
    sum1_full  = {1'b0, x6_r} + {1'b0, seven_r};
    inner_full = {1'b0, sum1_r} + {1'b0, br2_r};
    inner_val  = inner_full[EW] ? evs_pkg::CAP : inner_full[EW-1:0];
    acc_full   = {1'b0, acc_r} + {1'b0, term_r};
    acc_val    = acc_full[EW] ? evs_pkg::CAP : acc_full[EW-1:0];
    cnt_val    = (cnt_r == {CW{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  end

  assign slot_free = !out_valid_r || out_pop;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
      acc_r           <= '0;
      cnt_r           <= '0;
      ovf_r           <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            r2_r            <= cmd.word.squared_distance;
            last_r          <= cmd.word.last_pair;
            zero_r          <= cmd.zero_dist;
            sat_r           <= 1'b0;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= OW'(cmd.word.pair_sigma);
            mul_req_r.b     <= OW'(cmd.word.pair_sigma);
            state_r         <= S_SS;
          end
        end
        S_SS: begin
          if (mul_rsp.done) begin
            ss_r            <= mul_rsp.p[evs_pkg::SS_W-1:0];
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= OW'(cfg.lambda_squared);
            mul_req_r.b     <= OW'(mul_rsp.p[evs_pkg::SS_W-1:0]);
            state_r         <= S_SG;
          end
        end
        S_SG: begin
          if (mul_rsp.done) begin
            sg2_r           <= sg_val;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= OW'(cfg.inverse_cutoff_squared);
            mul_req_r.b     <= OW'(ss_r);
            state_r         <= S_A1;
          end
        end
        S_A1: begin
          if (mul_rsp.done) begin
            a1_r <= sg_val;
            if (zero_r) begin
              x_r             <= evs_pkg::CAP;
              sat_r           <= 1'b1;
              mul_req_r.start <= 1'b1;
              mul_req_r.a     <= evs_pkg::CAP;
              mul_req_r.b     <= evs_pkg::CAP;
              state_r         <= S_PX1;
            end else begin
              div_req_r.start    <= 1'b1;
              div_req_r.dividend <= evs_pkg::DIV_W'(sg2_r << FRAC_BITS);
              div_req_r.divisor  <= r2_r;
              state_r            <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            x_r             <= EW'(div_rsp.quotient);
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= OW'(div_rsp.quotient);
            mul_req_r.b     <= OW'(div_rsp.quotient);
            state_r         <= S_PX1;
          end
        end
        S_PX1: begin
          if (mul_rsp.done) begin
            sat_r           <= sat_r | q_ovf;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= q_val;
            mul_req_r.b     <= x_r;
            state_r         <= S_PX2;
          end
        end
        S_PX2: begin
          if (mul_rsp.done) begin
            sat_r           <= sat_r | q_ovf;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= q_val;
            mul_req_r.b     <= q_val;
            state_r         <= S_PX3;
          end
        end
        S_PX3: begin
          if (mul_rsp.done) begin
            sat_r           <= sat_r | q_ovf;
            x6_r            <= q_val;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= a1_r;
            mul_req_r.b     <= a1_r;
            state_r         <= S_PA1;
          end
        end
        S_PA1: begin
          if (mul_rsp.done) begin
            sat_r           <= sat_r | q_ovf;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= q_val;
            mul_req_r.b     <= a1_r;
            state_r         <= S_PA2;
          end
        end
        S_PA2: begin
          if (mul_rsp.done) begin
            sat_r           <= sat_r | q_ovf;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= q_val;
            mul_req_r.b     <= q_val;
            state_r         <= S_PA3;
          end
        end
        S_PA3: begin
          if (mul_rsp.done) begin
            sat_r           <= sat_r | q_ovf | (seven_full[EW+2:EW] != '0);
            seven_r         <= (seven_full[EW+2:EW] != '0) ? evs_pkg::CAP
                                                            : seven_full[EW-1:0];
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= OW'(cfg.slope_factor);
            mul_req_r.b     <= q_val;
            state_r         <= S_B;
          end
        end
        S_B: begin
          if (mul_rsp.done) begin
            sat_r           <= sat_r | sum1_full[EW];
            sum1_r          <= sum1_full[EW] ? evs_pkg::CAP : sum1_full[EW-1:0];
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= r16_val;
            mul_req_r.b     <= OW'(r2_r);
            state_r         <= S_BR;
          end
        end
        S_BR: begin
          if (mul_rsp.done) begin
            sat_r   <= sat_r | q_ovf;
            br2_r   <= q_val;
            state_r <= S_INNER;
          end
        end
        S_INNER: begin
          sat_r           <= sat_r | inner_full[EW];
          mul_req_r.start <= 1'b1;
          mul_req_r.a     <= OW'(cfg.energy_scale);
          mul_req_r.b     <= inner_val;
          state_r         <= S_TERM;
        end
        S_TERM: begin
          if (mul_rsp.done) begin
            term_r  <= r16_val;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (!last_r) begin
            acc_r   <= acc_val;
            cnt_r   <= cnt_val;
            ovf_r   <= ovf_r | sat_r | acc_full[EW];
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_r.total_energy <= acc_val;
            out_r.pair_count   <= cnt_val;
            out_r.saturated    <= ovf_r | sat_r | acc_full[EW];
            out_valid_r        <= 1'b1;
            acc_r              <= '0;
            cnt_r              <= '0;
            ovf_r              <= 1'b0;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign mul_req   = mul_req_r;
  assign div_req   = div_req_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### hw/rtl/evs_checker.sv
// Port-level checker of the excluded volume energy sum unit, bound to the top level.
// Depends on evs_pkg and excluded_volume_energy_sum_unit_defines.svh.
`timescale 1ns / 1ps
`include "excluded_volume_energy_sum_unit_defines.svh"

module evs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input evs_pkg::in_word_t  in_word,
  input logic               out_empty,
  input logic               out_pop,
  input evs_pkg::out_word_t out_word
);

  logic [2:0] pend_r;
  logic       last_in;
  logic       word_out;

  assign last_in  = in_push && !in_full && in_word.last_pair;
  assign word_out = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(last_in) - 3'(word_out);
    end
  end

  `EVS_ASSERT_ALWAYS(a_empty_after_reset, !rst_n, out_empty, "result queue not empty after reset")
  `EVS_ASSERT_NOW(a_word_has_cause, !out_empty, pend_r != 3'd0, "result word without a last pair")
  `EVS_ASSERT_NOW(a_count_nonzero, !out_empty, out_word.pair_count != '0, "result word counts no pair")
  `EVS_ASSERT_NEXT(a_word_holds, !out_empty && !out_pop, !out_empty && $stable(out_word), "waiting result word changed")

endmodule

bind excluded_volume_energy_sum_unit evs_checker u_evs_checker (.*);

### tb/excluded_volume_energy_sum_unit_tb.sv
// Testbench for the excluded volume energy sum unit: directed and random pair
// streams with a built-in fixed-point predictor and an in-order result check.
// Depends on evs_pkg and the excluded_volume_energy_sum_unit RTL.
`timescale 1ns / 1ps

module excluded_volume_energy_sum_unit_tb;

  localparam int FB  = evs_pkg::FRAC_BITS_DEF;
  localparam int CW  = evs_pkg::CFG_W;
  localparam int R2W = evs_pkg::R2_W;
  localparam int SGW = evs_pkg::SIG_W;
  localparam logic [63:0] RND = 64'd1 << (FB - 1);

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  evs_pkg::in_word_t in_word;
  logic out_empty;
  logic out_pop;
  evs_pkg::out_word_t out_word;
  logic cfg_wr_en;
  logic [evs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;

  logic [63:0] lam_sq, icut_sq, escale, slope;
  logic [63:0] energy_sum, pair_cnt;
  bit sum_sat;
  evs_pkg::out_word_t pending_sets[$];
  bit failed;
  bit calm;

  excluded_volume_energy_sum_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] clamp(input logic [127:0] v, inout bit sat);
    if (v > {80'd0, evs_pkg::CAP}) begin
      sat = 1'b1;
      return {16'd0, evs_pkg::CAP};
    end
    return v[63:0];
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] p, input logic [63:0] q,
                                       inout bit sat);
    logic [127:0] t;
    t = {64'd0, p} * {64'd0, q} + {64'd0, RND};
    return clamp(t >> FB, sat);
  endfunction

  function automatic logic [63:0] sixth_power(input logic [63:0] v, inout bit sat);
    logic [63:0] c;
    c = qmul(qmul(v, v, sat), v, sat);
    return qmul(c, c, sat);
  endfunction

  function automatic logic [63:0] scaled_square(input logic [63:0] k, input logic [63:0] s);
    return (k * s * s + (64'd1 << (15 + FB))) >> (16 + FB);
  endfunction

  function automatic bit accumulate_pair(input evs_pkg::in_word_t w,
                                         output evs_pkg::out_word_t res);
    logic [63:0] r2, s, sg2, x, x6, a6, b, seven_a, br2, inner, term;
    bit sat;
    sat = 1'b0;
    r2 = {40'd0, w.squared_distance};
    s = {44'd0, w.pair_sigma};
    sg2 = scaled_square(lam_sq, s);
    if (r2 == 0) begin
      x = {16'd0, evs_pkg::CAP};
      sat = 1'b1;
    end else begin
      x = clamp({64'd0, (sg2 << FB) / r2}, sat);
    end
    x6 = sixth_power(x, sat);
    a6 = sixth_power(scaled_square(icut_sq, s), sat);
    b = (slope * a6 + 64'h8000) >> 16;
    seven_a = clamp({64'd0, 64'd7 * a6}, sat);
    br2 = qmul(b, r2, sat);
    inner = clamp({64'd0, clamp({64'd0, x6 + seven_a}, sat) + br2}, sat);
    term = (escale * inner + 64'h8000) >> 16;
    energy_sum = clamp({64'd0, energy_sum + term}, sat);
    if (pair_cnt < 64'hFFFF_FFFF) pair_cnt = pair_cnt + 1;
    if (sat) sum_sat = 1'b1;
    res = '0;
    if (!w.last_pair) return 1'b0;
    res.total_energy = energy_sum[evs_pkg::ENERGY_W-1:0];
    res.pair_count = pair_cnt[evs_pkg::COUNT_W-1:0];
    res.saturated = sum_sat;
    energy_sum = 0;
    pair_cnt = 0;
    sum_sat = 1'b0;
    return 1'b1;
  endfunction

  always @(negedge clk) begin
    if (calm) out_pop <= 1'b1;
    else out_pop <= ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    evs_pkg::out_word_t exp_w;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_sets.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, out_word);
        failed = 1'b1;
      end else begin
        exp_w = pending_sets.pop_front();
        if (out_word.total_energy !== exp_w.total_energy) begin
          $display("%0t: total_energy expected %h actual %h", $realtime,
                   exp_w.total_energy, out_word.total_energy);
          failed = 1'b1;
        end
        if (out_word.pair_count !== exp_w.pair_count) begin
          $display("%0t: pair_count expected %0d actual %0d", $realtime,
                   exp_w.pair_count, out_word.pair_count);
          failed = 1'b1;
        end
        if (out_word.saturated !== exp_w.saturated) begin
          $display("%0t: saturated expected %b actual %b", $realtime,
                   exp_w.saturated, out_word.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic send_pair(input logic [R2W-1:0] r2, input logic [SGW-1:0] sg,
                           input logic last);
    evs_pkg::in_word_t w;
    evs_pkg::out_word_t res;
    w.squared_distance = r2;
    w.pair_sigma = sg;
    w.last_pair = last;
    if (!calm && $urandom_range(99) < 26) begin
      in_push = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_push = 1'b1;
    in_word = w;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (accumulate_pair(w, res)) pending_sets.push_back(res);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic drain;
    while (pending_sets.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input evs_pkg::cfg_idx_t idx, input logic [CW-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      evs_pkg::CFG_LAMBDA_SQ: lam_sq = val;
      evs_pkg::CFG_INV_CUT_SQ: icut_sq = val;
      evs_pkg::CFG_ENERGY_SCALE: escale = val;
      default: slope = val;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic write_all(input logic [CW-1:0] l, input logic [CW-1:0] c,
                           input logic [CW-1:0] e, input logic [CW-1:0] k);
    write_reg(evs_pkg::CFG_LAMBDA_SQ, l);
    write_reg(evs_pkg::CFG_INV_CUT_SQ, c);
    write_reg(evs_pkg::CFG_ENERGY_SCALE, e);
    write_reg(evs_pkg::CFG_SLOPE, k);
  endtask

  function automatic logic [31:0] ranged_bits(input int maxw);
    int n;
    n = $urandom_range(maxw, 1);
    return $urandom & ((32'd1 << n) - 1);
  endfunction

  task automatic random_sets(input int pairs);
    int left, len;
    logic [R2W-1:0] r2;
    left = pairs;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(6, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        r2 = ($urandom_range(29) == 0) ? '0 : R2W'(ranged_bits(R2W));
        send_pair(r2, SGW'(ranged_bits(SGW)), i == len - 1);
      end
      left = left - len;
    end
  endtask

  task automatic test_directed;
    send_pair(24'd65536, 20'd65536, 1'b1);
    send_pair('0, 20'd65536, 1'b1);
    send_pair(24'hFFFFFF, 20'hFFFFF, 1'b1);
    send_pair(24'hFFFFFF, '0, 1'b1);
    send_pair(24'd1, 20'd1, 1'b1);
    send_pair(24'd131072, 20'd70000, 1'b0);
    send_pair(24'd200000, 20'd50000, 1'b0);
    send_pair(24'd90000, 20'd60000, 1'b0);
    send_pair(24'd300000, 20'd65536, 1'b1);
    send_pair('0, '0, 1'b0);
    send_pair(24'd65536, 20'hFFFFF, 1'b1);
    send_pair(24'hAAAAAA, 20'h55555, 1'b1);
    send_pair(24'h555555, 20'hAAAAA, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes;
    write_all('0, '0, '0, '0);
    random_sets(40);
    drain();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_sets(40);
    drain();
    write_all(16'h0001, 16'hFFFF, 16'h0001, '0);
    random_sets(30);
    drain();
  endtask

  task automatic test_random_stream;
    for (int ph = 0; ph < 6; ph++) begin
      write_all(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
      calm = (ph == 2);
      random_sets(180);
      drain();
      calm = 1'b0;
    end
    write_all(evs_pkg::LAMBDA_SQ_RST, evs_pkg::INV_CUT_SQ_RST,
              evs_pkg::ENERGY_SCALE_RST, evs_pkg::SLOPE_RST);
    random_sets(500);
    drain();
  endtask

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    failed = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_word = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    lam_sq = evs_pkg::LAMBDA_SQ_RST;
    icut_sq = evs_pkg::INV_CUT_SQ_RST;
    escale = evs_pkg::ENERGY_SCALE_RST;
    slope = evs_pkg::SLOPE_RST;
    energy_sum = 0;
    pair_cnt = 0;
    sum_sat = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_register_extremes();
    test_random_stream();
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
